// ===== src/mcc_pkg.sv =====
`timescale 1ns / 1ps

package mcc_pkg;

    localparam int CLIQUE_SIZE  = 7;
    localparam int TOTAL_W      = 48;
    localparam int CFG_W        = 9;
    localparam int VTX_W        = 8;
    localparam int MAX_VERTICES = 256;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_COUNT = 1'b1;

    typedef logic [TOTAL_W-1:0] total_t;

endpackage

// ===== src/mcc_ram.sv =====
`timescale 1ns / 1ps

module mcc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/mono_clique7_counter.sv =====
`timescale 1ns / 1ps
// Edge writes are taken at one per cycle while the block is idle and no result is waiting.
// A count request walks increasing vertex tuples depth first, using the single adjacency
// read port: each candidate is screened in ST_CAND, then its edge to each earlier tuple member
// is read in ST_READ and checked in ST_CHECK in turn; in_stall is high meanwhile.
// Reset clears the control state and sets vertex_count to 8; the edge store is not cleared.

module mono_clique7_counter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [mcc_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      req_type,
    input  logic [7:0]                row_vertex,
    input  logic [7:0]                col_vertex,
    input  logic                      edge_colour,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [47:0]               clique_total
);

    import mcc_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = VW + 1;
    localparam int AW = 2 * VW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CAND  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CFG_W-1:0]  vcount_reg;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     tup_reg [CLIQUE_SIZE];
    logic [NW-1:0]     cand_reg, cand_next;
    logic [2:0]        depth_reg, depth_next;
    logic [2:0]        probe_reg, probe_next;
    logic              colour_reg [CLIQUE_SIZE];
    total_t            total_reg, total_next;
    logic              out_valid_reg;

    logic              accept_in, wr_en, rd_bit;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [NW-1:0]     n_eff, limit;

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign clique_total = total_reg;

    assign wr_en = accept_in && (req_type == REQ_WRITE) && (row_vertex < col_vertex)
                   && ({1'b0, col_vertex} < 9'(MAX_VERTICES));
    assign wr_addr = {row_vertex[VW-1:0], col_vertex[VW-1:0]};
    assign rd_addr = {tup_reg[probe_reg][VW-1:0], cand_reg[VW-1:0]};

    mcc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_adj (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (edge_colour),
        .rd_addr (rd_addr),
        .rd_data (rd_bit)
    );

    assign n_eff = (32'(vcount_reg) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                         : NW'(vcount_reg);
    // Highest candidate bound at this depth: v + (6 - depth) < n.
    assign limit = n_reg - NW'(3'd6 - depth_reg);

    always_comb
    begin
        state_next = state_reg;
        cand_next  = cand_reg;
        depth_next = depth_reg;
        probe_next = probe_reg;
        total_next = total_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in && req_type == REQ_COUNT)
                begin
                    total_next = '0;
                    cand_next  = '0;
                    depth_next = '0;
                    probe_next = '0;
                    state_next = (n_eff >= NW'(CLIQUE_SIZE)) ? ST_CAND : ST_DONE;
                end
            end
            ST_CAND:
            begin
                if (total_reg == TOTAL_MAX || cand_reg >= limit)
                begin
                    // Candidates at this depth are exhausted or the total saturated: back up one level, or finish.
                    if (depth_reg == 3'd0 || total_reg == TOTAL_MAX)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        depth_next = depth_reg - 3'd1;
                        cand_next  = tup_reg[depth_reg - 3'd1] + NW'(1);
                    end
                end
                else if (depth_reg == 3'd0)
                begin
                    depth_next = 3'd1;
                    cand_next  = cand_reg + NW'(1);
                end
                else
                begin
                    probe_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (depth_reg != 3'd1 && rd_bit != colour_reg[depth_reg - 3'd1])
                begin
                    cand_next  = cand_reg + NW'(1);
                    state_next = ST_CAND;
                end
                else if (probe_reg + 3'd1 < depth_reg)
                begin
                    probe_next = probe_reg + 3'd1;
                    state_next = ST_READ;
                end
                else if (depth_reg == 3'd6)
                begin
                    total_next = total_reg + total_t'(1);
                    cand_next  = cand_reg + NW'(1);
                    state_next = ST_CAND;
                end
                else
                begin
                    depth_next = depth_reg + 3'd1;
                    cand_next  = cand_reg + NW'(1);
                    state_next = ST_CAND;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= CFG_W'(8);
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            cand_reg      <= '0;
            depth_reg     <= '0;
            probe_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cand_reg  <= cand_next;
            depth_reg <= depth_next;
            probe_reg <= probe_next;
            total_reg <= total_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latched vertex count, tuple members and the colour fixed at each depth.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept_in)
        begin
            n_reg <= n_eff;
        end
        if (state_reg == ST_CAND && depth_reg == 3'd0 && cand_reg < limit
            && total_reg != TOTAL_MAX)
        begin
            tup_reg[0] <= cand_reg;
        end
        if (state_reg == ST_CHECK)
        begin
            if (depth_reg == 3'd1)
            begin
                colour_reg[1] <= rd_bit;
            end
            else if (probe_reg == 3'd0)
            begin
                colour_reg[depth_reg] <= colour_reg[depth_reg - 3'd1];
            end
            if (probe_reg + 3'd1 >= depth_reg)
            begin
                tup_reg[depth_reg] <= cand_reg;
            end
        end
    end

`ifndef SYNTHESIS
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while counting");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> out_valid)
        else $error("finished count not presented");
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg < 3'd7)
        else $error("tuple depth out of range");
    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) |-> $stable(clique_total))
        else $error("result changed while presented");
`endif

endmodule

// ===== dv/tb_mono_clique7_counter.sv =====
`timescale 1ns / 1ps

class clique_scoreboard;
    bit              colour_map [256][256];
    int unsigned     vertex_limit;
    logic [7:0]      tuple [7];
    mcc_pkg::total_t tally;
    mcc_pkg::total_t totals_q [$];
    int unsigned     mismatches;
    int unsigned     counts_seen;
    int unsigned     writes_seen;

    function new();
        vertex_limit = 8;
        mismatches   = 0;
        counts_seen  = 0;
        writes_seen  = 0;
    endfunction

    function void set_vertex_limit(logic [mcc_pkg::CFG_W-1:0] value);
        vertex_limit = 32'(value);
    endfunction

    // Depth-first walk over increasing tuples, dropping a branch at the first edge
    // whose colour differs from the colour fixed by the tuple's first edge.
    function void grow(int unsigned depth, int unsigned first, int unsigned n, bit colour);
        int unsigned v;
        bit          ok;
        bit          c;
        for (v = first; v + (mcc_pkg::CLIQUE_SIZE - 1 - depth) < n; v++)
        begin
            if (tally == mcc_pkg::TOTAL_MAX)
                return;
            c = colour;
            if (depth == 1)
                c = colour_map[tuple[0]][v];
            ok = 1'b1;
            for (int p = 0; p < depth; p++)
            begin
                if (colour_map[tuple[p]][v] != c)
                    ok = 1'b0;
            end
            if (ok)
            begin
                tuple[depth] = v[7:0];
                if (depth + 1 == mcc_pkg::CLIQUE_SIZE)
                    tally++;
                else
                    grow(depth + 1, v + 1, n, c);
            end
        end
    endfunction

    function void note_transfer(logic req, logic [7:0] row, logic [7:0] col, logic colour);
        int unsigned n;
        if (req == mcc_pkg::REQ_WRITE)
        begin
            writes_seen++;
            if (row < col)
                colour_map[row][col] = colour;
            return;
        end
        counts_seen++;
        n = (vertex_limit > 256) ? 256 : vertex_limit;
        tally = '0;
        if (n >= mcc_pkg::CLIQUE_SIZE)
            grow(0, 0, n, 1'b0);
        totals_q.push_back(tally);
    endfunction

    function void check_result(mcc_pkg::total_t actual);
        mcc_pkg::total_t want;
        if (totals_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result clique_total=%0d", $realtime, actual);
            return;
        end
        want = totals_q.pop_front();
        if (want !== actual)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: clique_total expected %0d, got %0d", $realtime, want, actual);
        end
    endfunction
endclass

module tb_mono_clique7_counter;
    import mcc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_stall;
    logic                 req_type;
    logic [7:0]           row_vertex;
    logic [7:0]           col_vertex;
    logic                 edge_colour;
    logic                 out_valid;
    logic                 out_stall;
    logic [47:0]          clique_total;

    clique_scoreboard     board;
    int unsigned          send_idle_pct;
    int unsigned          recv_idle_pct;

    mono_clique7_counter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .row_vertex   (row_vertex),
        .col_vertex   (col_vertex),
        .edge_colour  (edge_colour),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .clique_total (clique_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(clique_total);
    end

    task automatic send_item(logic req, logic [7:0] row, logic [7:0] col, logic colour);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req_type    <= req;
        row_vertex  <= row;
        col_vertex  <= col;
        edge_colour <= colour;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        board.note_transfer(req, row, col, colour);
    endtask

    // The register is only written once the block has drained and gone quiet.
    task automatic set_vertex_count(logic [CFG_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.totals_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        board.set_vertex_limit(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item(int unsigned bias);
        int unsigned pick;
        logic [7:0]  a;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 8)
            send_item(REQ_COUNT, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
        else if (pick < 82)
        begin
            a = 8'($urandom_range(10));
            b = 8'($urandom_range(11, a + 1));
            send_item(REQ_WRITE, a, b, $urandom_range(99) < bias);
        end
        else if (pick < 91)
            send_item(REQ_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
        else
        begin
            a = 8'($urandom_range(255));
            b = 8'($urandom_range(a));
            send_item(REQ_WRITE, a, b, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        int unsigned n;
        board         = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        req_type      = REQ_WRITE;
        row_vertex    = '0;
        col_vertex    = '0;
        edge_colour   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Load one colour across the first twelve vertices so that every later count
        // reads only edges that have been written.
        for (int r = 0; r < 12; r++)
            for (int c = r + 1; c < 12; c++)
                send_item(REQ_WRITE, 8'(r), 8'(c), 1'b1);
        send_item(REQ_COUNT, 8'hFF, 8'h00, 1'b1);
        set_vertex_count(9'h1FF);
        set_vertex_count(9'd0);
        send_item(REQ_COUNT, 8'h00, 8'hFF, 1'b0);
        set_vertex_count(9'd6);
        send_item(REQ_COUNT, 8'h00, 8'h00, 1'b0);
        set_vertex_count(9'd7);
        send_item(REQ_COUNT, 8'h00, 8'h00, 1'b0);
        // Ignored writes: diagonal and lower triangle; then a write at the top of the vertex range.
        send_item(REQ_WRITE, 8'd3, 8'd3, 1'b0);
        send_item(REQ_WRITE, 8'd5, 8'd2, 1'b0);
        send_item(REQ_WRITE, 8'hFE, 8'hFF, 1'b0);
        send_item(REQ_COUNT, 8'h00, 8'h00, 1'b0);
        send_item(REQ_WRITE, 8'd0, 8'd6, 1'b0);
        send_item(REQ_COUNT, 8'h00, 8'h00, 1'b0);
        set_vertex_count(9'd12);
        send_item(REQ_COUNT, 8'h00, 8'h00, 1'b0);

        for (int blk = 0; blk < 12; blk++)
        begin
            if (blk < 4)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 73;
            end
            else if (blk < 8)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(9))
                0:       n = $urandom_range(6);
                1:       n = $urandom_range(12, 11);
                default: n = $urandom_range(10, 7);
            endcase
            set_vertex_count(CFG_W'(n));
            for (int i = 0; i < 100; i++)
                random_item((blk % 3 == 0) ? 90 : 50);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (board.totals_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Run covered %0d edge writes and %0d count requests over several vertex counts.",
                 board.writes_seen, board.counts_seen);
        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
